// ===== rtl/fbtb_pkg.sv =====
// Shared types, constants and the predictor next-state function for the branch target buffer.
package fbtb_pkg;

    localparam int DEPTH  = 8;
    localparam int ADDR_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1) > 0 ? $clog2(DEPTH + 1) : 1;
    localparam int Q_DEPTH = 2;
    localparam int Q_IDX_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        ST_STRONG_NT = 2'd0,
        ST_WEAK_NT   = 2'd1,
        ST_WEAK_T    = 2'd2,
        ST_STRONG_T  = 2'd3
    } t_pstate;

    typedef struct packed {
        t_addr branch_pc;
        t_addr branch_target;
        t_addr next_pc;
        logic  target_eq;
    } t_item;

    typedef struct packed {
        logic  predicted_taken;
        t_addr predicted_target;
        logic  table_hit;
        logic  mispredict;
    } t_result;

    function automatic t_pstate next_state(input t_pstate s, input logic taken);
        t_pstate r;
        case (s)
            ST_STRONG_NT: r = taken ? ST_WEAK_NT  : ST_STRONG_NT;
            ST_WEAK_NT:   r = taken ? ST_STRONG_T : ST_STRONG_NT;
            ST_WEAK_T:    r = taken ? ST_STRONG_T : ST_STRONG_NT;
            ST_STRONG_T:  r = taken ? ST_STRONG_T : ST_WEAK_T;
            default:      r = ST_STRONG_NT;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/fbtb_front.sv =====
// Front end: accepts branch transactions, classifies them and registers them.
module fbtb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fbtb_pkg::t_addr   i_branch_pc,
    input  fbtb_pkg::t_addr   i_branch_target,
    input  fbtb_pkg::t_addr   i_next_pc,
    output logic              o_valid,
    input  logic              i_ready,
    output fbtb_pkg::t_item   o_item
);
    import fbtb_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item, n_item;

    assign o_in_ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            n_valid              = 1'b1;
            n_item.branch_pc     = i_branch_pc;
            n_item.branch_target = i_branch_target;
            n_item.next_pc       = i_next_pc;
            n_item.target_eq     = (i_next_pc == i_branch_target);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

// ===== rtl/fbtb_queue.sv =====
// Short queue between front end and back end.
module fbtb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_not_full,
    input  fbtb_pkg::t_item  i_item,
    input  logic             i_pop,
    output logic             o_not_empty,
    output fbtb_pkg::t_item  o_item
);
    import fbtb_pkg::*;

    t_item               r_mem [Q_DEPTH];
    logic [Q_IDX_W-1:0]  r_wp, n_wp, r_rp, n_rp;
    logic [Q_CNT_W-1:0]  r_cnt, n_cnt;
    logic                push_ok, pop_ok;

    assign o_not_full  = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_item      = r_mem[r_rp];
    assign push_ok     = i_push && o_not_full;
    assign pop_ok      = i_pop && o_not_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wp = (r_wp == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop_ok) begin
            n_rp = (r_rp == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push_ok && pop_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push_ok) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== rtl/fbtb_back.sv =====
// Back end: associative table lookup, allocation, predictor update, result register.
module fbtb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_pop,
    input  fbtb_pkg::t_item    i_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fbtb_pkg::t_result  o_result
);
    import fbtb_pkg::*;

    t_addr   r_tag  [DEPTH];
    t_pstate r_pred [DEPTH];
    t_addr   r_tgt  [DEPTH];
    t_cnt    r_fill, n_fill;
    t_idx    r_oldest, n_oldest;
    t_pstate r_init;
    logic    r_out_valid, n_out_valid;
    t_result r_out, n_out;

    logic    full, hit, taken, ptaken, tgt_eq;
    t_idx    mslot, slot;
    t_pstate st;
    t_addr   ptgt;

    assign full        = (r_fill == CNT_W'(DEPTH));
    assign o_pop       = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        hit   = 1'b0;
        mslot = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_fill) && (r_tag[i] == i_item.branch_pc)) begin
                hit   = 1'b1;
                mslot = IDX_W'(i);
            end
        end
    end

    always_comb begin
        if (hit) begin
            slot = mslot;
        end else if (full) begin
            slot = r_oldest;
        end else begin
            slot = r_fill[IDX_W-1:0];
        end
        st     = hit ? r_pred[slot] : r_init;
        ptgt   = hit ? r_tgt[slot] : '0;
        ptaken = st[1];
        tgt_eq = (i_item.next_pc == ptgt);
        taken  = tgt_eq || i_item.target_eq;
    end

    always_comb begin
        n_fill      = r_fill;
        n_oldest    = r_oldest;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_pop) begin
            n_out_valid               = 1'b1;
            n_out.predicted_taken     = ptaken;
            n_out.predicted_target    = ptgt;
            n_out.table_hit           = hit;
            n_out.mispredict          = !((ptaken && tgt_eq) || (!ptaken && !taken));
            if (!hit && !full) begin
                n_fill = r_fill + 1'b1;
            end
            if (!hit && full) begin
                n_oldest = (slot == IDX_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_oldest    <= '0;
            r_init      <= ST_WEAK_NT;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_oldest    <= n_oldest;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_init <= t_pstate'(i_cfg_data);
            end
        end
        r_out <= n_out;
        if (o_pop) begin
            r_tag[slot]  <= i_item.branch_pc;
            r_pred[slot] <= next_state(st, taken);
            r_tgt[slot]  <= i_item.target_eq ? i_item.branch_target : ptgt;
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("fill count beyond table depth");

    a_oldest_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full |-> r_oldest == '0)
        else $error("replacement pointer moved before table full");

    a_fill_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_fill >= $past(r_fill))
        else $error("fill count decreased");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && hit |=> $stable(r_fill) && $stable(r_oldest))
        else $error("allocation state changed on a hit");
`endif

endmodule

// ===== rtl/fifo_btb_two_bit_branch_predictor.sv =====
// Top level: branch target buffer with four-state predictor and FIFO replacement.
// Transactions are registered in the front end, held in the queue, and results are registered in the back end.
// Throughput: one transaction per cycle while results are accepted, set by the
// combinational associative lookup and the update of the eight-entry table in the back end.
// Reset clears the fill count and replacement pointer and sets the initial
// state register to weak not taken; table contents are not cleared.
module fifo_btb_two_bit_branch_predictor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fbtb_pkg::t_addr     i_branch_pc,
    input  fbtb_pkg::t_addr     i_branch_target,
    input  fbtb_pkg::t_addr     i_next_pc,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_predicted_taken,
    output fbtb_pkg::t_addr     o_predicted_target,
    output logic                o_table_hit,
    output logic                o_mispredict
);
    import fbtb_pkg::*;

    logic    f_valid, q_not_full, q_not_empty, b_pop;
    t_item   f_item, q_item;
    t_result b_result;

    fbtb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_branch_pc     (i_branch_pc),
        .i_branch_target (i_branch_target),
        .i_next_pc       (i_next_pc),
        .o_valid         (f_valid),
        .i_ready         (q_not_full),
        .o_item          (f_item)
    );

    fbtb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_valid),
        .o_not_full  (q_not_full),
        .i_item      (f_item),
        .i_pop       (b_pop),
        .o_not_empty (q_not_empty),
        .o_item      (q_item)
    );

    fbtb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (q_not_empty),
        .o_pop       (b_pop),
        .i_item      (q_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (b_result)
    );

    assign o_predicted_taken  = b_result.predicted_taken;
    assign o_predicted_target = b_result.predicted_target;
    assign o_table_hit        = b_result.table_hit;
    assign o_mispredict       = b_result.mispredict;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the branch target buffer with four-state predictor.
module tb_top;
    import fbtb_pkg::*;

    typedef enum int {OP_ITEM, OP_CFG, OP_MODE, OP_DRAIN} t_stim_op;
    typedef enum int {MODE_NONE, MODE_SEND, MODE_RECV, MODE_BOTH} t_idle_mode;

    typedef struct {
        t_stim_op op;
        t_addr    pc;
        t_addr    tgt;
        t_addr    nxt;
        int       arg;
    } t_stim;

    localparam int QUIET_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_data = 2'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_addr       i_branch_pc = '0;
    t_addr       i_branch_target = '0;
    t_addr       i_next_pc = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic        o_predicted_taken;
    t_addr       o_predicted_target;
    logic        o_table_hit;
    logic        o_mispredict;

    t_stim       branch_q[$];
    t_result     outcome_q[$];

    t_addr       btb_tag[DEPTH];
    t_pstate     btb_state[DEPTH];
    t_addr       btb_target[DEPTH];
    int          btb_fill = 0;
    int          btb_oldest = 0;
    t_pstate     cfg_init = ST_WEAK_NT;

    int          send_pct = 0;
    int          stall_pct = 0;
    int          errors = 0;
    int          quiet_cycles = 0;

    fifo_btb_two_bit_branch_predictor u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_branch_pc        (i_branch_pc),
        .i_branch_target    (i_branch_target),
        .i_next_pc          (i_next_pc),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_predicted_taken  (o_predicted_taken),
        .o_predicted_target (o_predicted_target),
        .o_table_hit        (o_table_hit),
        .o_mispredict       (o_mispredict)
    );

    initial forever #6 i_clk = ~i_clk;

    function automatic void predict_branch(input t_addr pc, input t_addr comp,
                                           input t_addr nxt);
        int      slot;
        bit      hit;
        bit      taken;
        t_pstate st;
        t_result r;
        slot = 0;
        hit  = 1'b0;
        for (int i = 0; i < btb_fill; i++) begin
            if (!hit && btb_tag[i] == pc) begin
                hit  = 1'b1;
                slot = i;
            end
        end
        if (!hit) begin
            if (btb_fill < DEPTH) begin
                slot = btb_fill;
                btb_fill++;
            end else begin
                slot = btb_oldest;
                btb_oldest = (btb_oldest + 1) % DEPTH;
            end
            btb_tag[slot]    = pc;
            btb_state[slot]  = cfg_init;
            btb_target[slot] = '0;
        end
        st    = btb_state[slot];
        taken = (nxt == btb_target[slot]) || (nxt == comp);
        r.predicted_taken  = (st == ST_WEAK_T) || (st == ST_STRONG_T);
        r.predicted_target = btb_target[slot];
        r.table_hit        = hit;
        r.mispredict       = !((r.predicted_taken && nxt == btb_target[slot]) ||
                               (!r.predicted_taken && !taken));
        case (st)
            ST_STRONG_NT: btb_state[slot] = taken ? ST_WEAK_NT : ST_STRONG_NT;
            ST_WEAK_NT:   btb_state[slot] = taken ? ST_STRONG_T : ST_STRONG_NT;
            ST_WEAK_T:    btb_state[slot] = taken ? ST_STRONG_T : ST_STRONG_NT;
            default:      btb_state[slot] = taken ? ST_STRONG_T : ST_WEAK_T;
        endcase
        if (nxt == comp) begin
            btb_target[slot] = comp;
        end
        outcome_q = {outcome_q, r};
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void push_branch(input t_addr pc, input t_addr tgt, input t_addr nxt);
        t_stim s;
        s.op  = OP_ITEM;
        s.pc  = pc;
        s.tgt = tgt;
        s.nxt = nxt;
        s.arg = 0;
        branch_q = {branch_q, s};
    endfunction

    function automatic void push_ctrl(input t_stim_op op, input int arg);
        t_stim s;
        s.op  = op;
        s.pc  = '0;
        s.tgt = '0;
        s.nxt = '0;
        s.arg = arg;
        branch_q = {branch_q, s};
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic  valid_n;
        logic  we_n;
        t_stim head;
        valid_n = i_in_valid;
        we_n    = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_branch(i_branch_pc, i_branch_target, i_next_pc);
                valid_n = 1'b0;
            end
            if (!valid_n && branch_q.size() > 0) begin
                head = branch_q[0];
                case (head.op)
                    OP_ITEM: begin
                        if ($urandom_range(99) >= send_pct) begin
                            branch_q.delete(0);
                            i_branch_pc     <= head.pc;
                            i_branch_target <= head.tgt;
                            i_next_pc       <= head.nxt;
                            valid_n = 1'b1;
                        end
                    end
                    OP_MODE: begin
                        branch_q.delete(0);
                        case (t_idle_mode'(head.arg))
                            MODE_SEND: begin
                                send_pct = 65;
                                stall_pct <= 0;
                            end
                            MODE_RECV: begin
                                send_pct = 0;
                                stall_pct <= 65;
                            end
                            MODE_BOTH: begin
                                send_pct = 22;
                                stall_pct <= 22;
                            end
                            default: begin
                                send_pct = 0;
                                stall_pct <= 0;
                            end
                        endcase
                    end
                    OP_DRAIN: begin
                        if (outcome_q.size() == 0) begin
                            branch_q.delete(0);
                        end
                    end
                    default: begin
                        // register write only once the pipeline is empty
                        if (outcome_q.size() == 0) begin
                            branch_q.delete(0);
                            we_n = 1'b1;
                            i_cfg_data <= head.arg[1:0];
                            cfg_init = t_pstate'(head.arg[1:0]);
                        end
                    end
                endcase
            end
        end
        i_in_valid <= valid_n;
        i_cfg_we   <= we_n;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result: taken %b target %h hit %b mispredict %b",
                         $time, o_predicted_taken, o_predicted_target, o_table_hit,
                         o_mispredict);
                errors++;
            end else begin
                want = outcome_q[0];
                outcome_q.delete(0);
                check_field("predicted_taken", want.predicted_taken, o_predicted_taken);
                check_field("predicted_target", want.predicted_target, o_predicted_target);
                check_field("table_hit", want.table_hit, o_table_hit);
                check_field("mispredict", want.mispredict, o_mispredict);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_addr pool_pc[16];
        t_addr pool_tgt[16];
        t_addr pool_old[16];
        int    pool_bias[16];
        int    pool_n;
        int    k;
        int    sel;
        t_addr nxt;
        int    cfg_seq[8];

        cfg_seq = '{0, 3, 2, 1, 3, 0, 1, 2};

        // directed: address extremes, hits, fill and a full wrap of replacement
        push_ctrl(OP_MODE, MODE_NONE);
        push_branch(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_branch(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_branch(32'h0000_0000, 32'h0000_0100, 32'h0000_0004);
        push_branch(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        push_branch(32'h0000_0000, 32'h0000_0100, 32'h0000_0100);
        push_branch(32'h0000_0000, 32'h0000_0100, 32'h0000_0100);
        for (int j = 1; j <= 14; j++) begin
            push_branch(t_addr'(j * 16), t_addr'(j * 16 + 32'h1000),
                        (j % 2) ? t_addr'(j * 16 + 32'h1000) : t_addr'(j * 16 + 4));
        end
        push_branch(32'h0000_0000, 32'h0000_0100, 32'h0000_0000);
        push_ctrl(OP_DRAIN, 0);

        for (int ph = 0; ph < 8; ph++) begin
            push_ctrl(OP_CFG, cfg_seq[ph]);
            push_ctrl(OP_MODE, ph % 4);
            pool_n = $urandom_range(14, 3);
            for (int j = 0; j < pool_n; j++) begin
                pool_pc[j]   = $urandom;
                pool_tgt[j]  = $urandom;
                pool_old[j]  = $urandom;
                pool_bias[j] = $urandom_range(10);
            end
            repeat (250) begin
                k   = $urandom_range(pool_n - 1);
                sel = $urandom_range(99);
                if (sel < 8) begin
                    push_branch($urandom, $urandom, $urandom);
                end else begin
                    if (sel < 14) begin
                        pool_old[k] = pool_tgt[k];
                        pool_tgt[k] = $urandom;
                    end
                    if ($urandom_range(9) < pool_bias[k]) begin
                        nxt = pool_tgt[k];
                    end else if ($urandom_range(1) == 0) begin
                        nxt = pool_pc[k] + 4;
                    end else begin
                        nxt = pool_old[k];
                    end
                    push_branch(pool_pc[k], pool_tgt[k], nxt);
                end
                if ($urandom_range(149) == 0) begin
                    push_ctrl(OP_DRAIN, 0);
                end
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (branch_q.size() > 0 || i_in_valid || outcome_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fbtb_pkg.sv
rtl/fbtb_front.sv
rtl/fbtb_queue.sv
rtl/fbtb_back.sv
rtl/fifo_btb_two_bit_branch_predictor.sv
tb/sv/tb_top.sv
